[rtl/core/mbfb_pkg.sv]
// Package with the frame builder's constants, payload types and command format.
package mbfb_pkg;

   localparam logic [7:0] START_SHORT       = 8'h10;
   localparam logic [7:0] START_LONG        = 8'h68;
   localparam logic [7:0] STOP_CHAR         = 8'h16;
   localparam logic [7:0] ACK_CHAR          = 8'hE5;
   localparam logic [7:0] SHORT_PAYLOAD_LEN = 8'd2;
   localparam logic [7:0] MAX_LEN_RESET     = 8'd255;

   localparam int STEP_W = 3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] frame_len;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
      logic       error;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_ERROR,
      CMD_SINGLE,
      CMD_SHORT,
      CMD_LONG,
      CMD_DATA,
      CMD_DATA_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data_byte;
      logic [7:0]   frame_len;
      logic [7:0]   sum;
   } cmd_type;

endpackage

[rtl/core/mbfb_front.sv]
// Front end: takes requests, tracks frame state and issues emit commands.
module mbfb_front
   import mbfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  req_type    req_data,
   input  logic       csr_valid,
   input  logic [7:0] csr_data,
   input  logic       cmd_full,
   output logic       cmd_push,
   output cmd_type    cmd_data
);

   logic       in_frame_ff,   in_frame_in;
   logic       discarding_ff, discarding_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] sum_ff,        sum_in;
   logic [7:0] max_len_ff;

   logic       accept;
   logic [7:0] left_dec;
   logic [7:0] sum_add;

   assign accept   = req_push && !cmd_full;
   assign left_dec = bytes_left_ff - ((bytes_left_ff != 8'd0) ? 8'd1 : 8'd0);
   assign sum_add  = sum_ff + req_data.data_byte;

   always_comb begin
      in_frame_in        = in_frame_ff;
      discarding_in      = discarding_ff;
      bytes_left_in      = bytes_left_ff;
      sum_in             = sum_ff;
      cmd_push           = 1'b0;
      cmd_data.kind      = CMD_DATA;
      cmd_data.data_byte = req_data.data_byte;
      cmd_data.frame_len = req_data.frame_len;
      cmd_data.sum       = sum_add;
      if (accept) begin
         priority if (!in_frame_ff) begin
            cmd_push = 1'b1;
            priority if (req_data.frame_len == 8'd0) begin
               cmd_data.kind = CMD_ERROR;
            end else if (req_data.frame_len == 8'd1) begin
               cmd_data.kind = CMD_SINGLE;
            end else if (req_data.frame_len > max_len_ff) begin
               // reject, then drop the rest of this frame
               cmd_data.kind = CMD_ERROR;
               in_frame_in   = 1'b1;
               discarding_in = 1'b1;
               bytes_left_in = req_data.frame_len - 8'd1;
            end else begin
               cmd_data.kind = (req_data.frame_len == SHORT_PAYLOAD_LEN) ?
                               CMD_SHORT : CMD_LONG;
               sum_in        = req_data.data_byte;
               bytes_left_in = req_data.frame_len - 8'd1;
               in_frame_in   = 1'b1;
               discarding_in = 1'b0;
            end
         end else if (discarding_ff) begin
            bytes_left_in = left_dec;
            if (left_dec == 8'd0) begin
               discarding_in = 1'b0;
               in_frame_in   = 1'b0;
            end
         end else begin
            cmd_push      = 1'b1;
            bytes_left_in = left_dec;
            sum_in        = sum_add;
            if (left_dec == 8'd0) begin
               cmd_data.kind = CMD_DATA_END;
               in_frame_in   = 1'b0;
               sum_in        = 8'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         discarding_ff <= 1'b0;
         bytes_left_ff <= 8'd0;
         sum_ff        <= 8'd0;
         max_len_ff    <= MAX_LEN_RESET;
      end else begin
         in_frame_ff   <= in_frame_in;
         discarding_ff <= discarding_in;
         bytes_left_ff <= bytes_left_in;
         sum_ff        <= sum_in;
         if (csr_valid) begin
            max_len_ff <= csr_data;
         end
      end
   end

endmodule

[rtl/core/mbfb_cmdq.sv]
// Short command queue between the front end and the byte emitter.
module mbfb_cmdq
   import mbfb_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/mbfb_back.sv]
// Back end: expands each command into framed bytes, one per cycle while the result side keeps taking them.
module mbfb_back
   import mbfb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_head,
   output logic    cmd_pop,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff;
   rsp_type           out_ff;

   logic              emit;
   logic [STEP_W-1:0] last_step;
   logic              is_last;
   rsp_type           next_rsp;

   assign emit    = !cmd_empty && (!out_valid_ff || rsp_pop);
   assign is_last = (step_ff == last_step);
   assign cmd_pop = emit && is_last;

   always_comb begin
      next_rsp.out_byte  = cmd_head.data_byte;
      next_rsp.run_last  = 1'b0;
      next_rsp.frame_end = 1'b0;
      next_rsp.error     = 1'b0;
      last_step          = '0;
      unique case (cmd_head.kind)
         CMD_ERROR: begin
            next_rsp.out_byte  = 8'd0;
            next_rsp.frame_end = 1'b1;
            next_rsp.error     = 1'b1;
         end
         CMD_SINGLE: begin
            next_rsp.out_byte  = ACK_CHAR;
            next_rsp.frame_end = 1'b1;
         end
         CMD_SHORT: begin
            last_step = STEP_W'(1);
            if (step_ff == '0) begin
               next_rsp.out_byte = START_SHORT;
            end
         end
         CMD_LONG: begin
            // header: start, length, length, start, then the first byte
            last_step = STEP_W'(4);
            unique case (step_ff)
               STEP_W'(0), STEP_W'(3): next_rsp.out_byte = START_LONG;
               STEP_W'(1), STEP_W'(2): next_rsp.out_byte = cmd_head.frame_len;
               default:                next_rsp.out_byte = cmd_head.data_byte;
            endcase
         end
         CMD_DATA: begin
         end
         CMD_DATA_END: begin
            last_step = STEP_W'(2);
            if (step_ff == STEP_W'(1)) begin
               next_rsp.out_byte = cmd_head.sum;
            end else if (step_ff == STEP_W'(2)) begin
               next_rsp.out_byte  = STOP_CHAR;
               next_rsp.frame_end = 1'b1;
            end
         end
         default: begin
            next_rsp.out_byte = 8'd0;
         end
      endcase
      next_rsp.run_last = (step_ff == last_step);
   end

   always_comb begin
      step_in = step_ff;
      if (emit) begin
         step_in = is_last ? '0 : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // hold the waiting result byte until it is taken
   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= next_rsp;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[rtl/core/mbus_frame_builder.sv]
// The first byte of a request passes through the command queue and then the output register.
// Requests are taken one per cycle while the command queue is not full; each command's bytes
// (up to five for a long frame's first byte) leave one at a time through the single-byte output register.
// A small command queue absorbs header and trailer bytes while requests keep arriving.
// Reset is synchronous and active high: frame state cleared, maximum length back to 255.
module mbus_frame_builder
   import mbfb_pkg::*;
#(
   parameter int CMD_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_in, cmd_head;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full;

   mbfb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in)
   );

   mbfb_cmdq #(
      .DEPTH (CMD_DEPTH)
   ) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   mbfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/sv/tb_mbus_frame_builder.sv]
// Self-checking testbench for the frame builder: queue-style request and result sides.
`timescale 1ns / 100ps

module tb_mbus_frame_builder;
   import mbfb_pkg::*;

   localparam int HOLD_CYCLES     = 300;
   localparam int STALL_LIMIT     = 3000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int IDLE_PERCENT    = 22;
   localparam int REPORT_LIMIT    = 10;

   logic       clock;
   logic       reset     = 1'b1;
   logic       req_push  = 1'b0;
   logic       req_full;
   req_type    req_data  = '0;
   logic       rsp_empty;
   logic       rsp_pop   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data  = 8'd0;

   // Stimulus controls; the hold counters belong to the result side.
   logic       calm      = 1'b0;
   logic [3:0] hold_seq  = 4'd0;
   logic [3:0] hold_seen = 4'd0;
   int         hold_left = 0;

   // Predicted frame state.
   logic       fb_in_frame;
   logic [7:0] fb_bytes_left;
   logic [7:0] fb_sum;
   logic       fb_dropping;
   logic [7:0] limit_model;

   rsp_type    framed_bytes_due[$];
   int         result_errors = 0;
   int         requests_taken = 0;
   int         bytes_checked = 0;
   int         frames_sent = 0;
   int         stall_cycles = 0;

   mbus_frame_builder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_type frame_byte(input logic [7:0] b, input logic fe,
                                          input logic err);
      rsp_type r;
      r.out_byte  = b;
      r.run_last  = 1'b0;
      r.frame_end = fe;
      r.error     = err;
      return r;
   endfunction

   // Work out the bytes one request produces and queue them in order.
   function automatic void build_frame_bytes(input req_type r);
      rsp_type burst[$];
      rsp_type item;
      if (!fb_in_frame) begin
         if (r.frame_len == 8'd0) begin
            burst.push_back(frame_byte(8'd0, 1'b1, 1'b1));
         end else if (r.frame_len == 8'd1) begin
            burst.push_back(frame_byte(ACK_CHAR, 1'b1, 1'b0));
         end else if (r.frame_len > limit_model) begin
            // reject, then drop the rest of the frame silently
            burst.push_back(frame_byte(8'd0, 1'b1, 1'b1));
            fb_in_frame   = 1'b1;
            fb_dropping   = 1'b1;
            fb_bytes_left = r.frame_len - 8'd1;
         end else begin
            if (r.frame_len == SHORT_PAYLOAD_LEN) begin
               burst.push_back(frame_byte(START_SHORT, 1'b0, 1'b0));
            end else begin
               burst.push_back(frame_byte(START_LONG, 1'b0, 1'b0));
               burst.push_back(frame_byte(r.frame_len, 1'b0, 1'b0));
               burst.push_back(frame_byte(r.frame_len, 1'b0, 1'b0));
               burst.push_back(frame_byte(START_LONG, 1'b0, 1'b0));
            end
            burst.push_back(frame_byte(r.data_byte, 1'b0, 1'b0));
            fb_sum        = r.data_byte;
            fb_bytes_left = r.frame_len - 8'd1;
            fb_in_frame   = 1'b1;
            fb_dropping   = 1'b0;
         end
      end else if (fb_dropping) begin
         if (fb_bytes_left != 8'd0) fb_bytes_left = fb_bytes_left - 8'd1;
         if (fb_bytes_left == 8'd0) begin
            fb_dropping = 1'b0;
            fb_in_frame = 1'b0;
         end
      end else begin
         burst.push_back(frame_byte(r.data_byte, 1'b0, 1'b0));
         fb_sum = fb_sum + r.data_byte;
         if (fb_bytes_left != 8'd0) fb_bytes_left = fb_bytes_left - 8'd1;
         if (fb_bytes_left == 8'd0) begin
            burst.push_back(frame_byte(fb_sum, 1'b0, 1'b0));
            burst.push_back(frame_byte(STOP_CHAR, 1'b1, 1'b0));
            fb_in_frame = 1'b0;
            fb_sum      = 8'd0;
         end
      end
      for (int i = 0; i < burst.size(); i++) begin
         item          = burst[i];
         item.run_last = (i == burst.size() - 1);
         framed_bytes_due.push_back(item);
      end
   endfunction

   function automatic void compare_framed_byte(input rsp_type got);
      rsp_type want;
      if (framed_bytes_due.size() == 0) begin
         result_errors++;
         if (result_errors <= REPORT_LIMIT)
            $display("%0t: unexpected byte %h last %b end %b err %b", $realtime,
                     got.out_byte, got.run_last, got.frame_end, got.error);
         return;
      end
      want = framed_bytes_due.pop_front();
      bytes_checked++;
      if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
          got.frame_end !== want.frame_end || got.error !== want.error) begin
         result_errors++;
         if (result_errors <= REPORT_LIMIT)
            $display("%0t: byte %h/%h last %b/%b end %b/%b err %b/%b (expected/actual)",
                     $realtime, want.out_byte, got.out_byte, want.run_last, got.run_last,
                     want.frame_end, got.frame_end, want.error, got.error);
      end
   endfunction

   // Predict on each taken request before checking the byte popped at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         fb_in_frame   = 1'b0;
         fb_bytes_left = 8'd0;
         fb_sum        = 8'd0;
         fb_dropping   = 1'b0;
         limit_model   = MAX_LEN_RESET;
      end else begin
         if (req_push && req_full === 1'b0) begin
            build_frame_bytes(req_data);
            requests_taken++;
         end
         if (csr_valid && csr_ready === 1'b1) limit_model = csr_data;
         if (rsp_pop && rsp_empty === 1'b0) compare_framed_byte(rsp_data);
      end
   end

   // Result side: random pops, or a long hold whenever the sequence asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_pop   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else begin
         rsp_pop <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && req_full === 1'b0) || (rsp_pop && rsp_empty === 1'b0) ||
          (csr_valid && csr_ready === 1'b1))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_request(input logic [7:0] data_byte, input logic [7:0] frame_len);
      req_type item;
      item.data_byte = data_byte;
      item.frame_len = frame_len;
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full !== 1'b0) @(posedge clock);
   endtask

   // Send a whole frame; later bytes carry noise in frame_len, which must be ignored.
   task automatic send_frame(input logic [7:0] len, output int sent_items);
      int n;
      n = (len == 8'd0) ? 1 : int'(len);
      sent_items = n;
      for (int i = 0; i < n; i++)
         send_request(8'($urandom_range(255)), (i == 0) ? len : 8'($urandom_range(255)));
      frames_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (framed_bytes_due.size() != 0) @(posedge clock);
      // dropped requests leave no bytes behind, so allow the pipeline to empty
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [7:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_frame_len(input logic [7:0] lim);
      int r;
      int hi;
      r  = $urandom_range(99);
      hi = (lim < 16) ? int'(lim) : 16;
      if (r < 4) return 0;
      if (r < 12) return $urandom_range(48);
      if (r < 20) return 1;
      if (r < 32) return 2;
      if (r < 90) return $urandom_range(hi, 3);
      if (r < 98) return $urandom_range((lim < 64) ? int'(lim) : 64, 3);
      return $urandom_range((lim < 96) ? int'(lim) : 96, 3);
   endfunction

   task automatic test_frame_kinds();
      send_request(8'hFF, 8'd0);
      send_request(8'hFF, 8'd1);
      send_request(8'h00, 8'd1);
      send_request(8'h00, 8'd2);
      send_request(8'hFF, 8'h00);
      // checksum wraps past 8 bits
      send_request(8'hFF, 8'd3);
      send_request(8'hFF, 8'hFF);
      send_request(8'hFF, 8'hAA);
      send_request(8'h01, 8'd4);
      send_request(8'h02, 8'h55);
      send_request(8'h03, 8'd0);
      send_request(8'h80, 8'd1);
      frames_sent += 6;
   endtask

   task automatic test_length_limit();
      int sent;
      write_max_len(8'd3);
      send_frame(8'd3, sent);
      send_frame(8'd4, sent);
      send_frame(8'd2, sent);
      // below the short length even a two-byte payload is refused
      write_max_len(8'd1);
      send_frame(8'd2, sent);
      send_frame(8'd1, sent);
      write_max_len(8'd0);
      send_frame(8'd1, sent);
      send_frame(8'd0, sent);
      write_max_len(8'd255);
   endtask

   task automatic test_limit_edge();
      int sent;
      write_max_len(8'd40);
      send_frame(8'd41, sent);
      send_frame(8'd40, sent);
      write_max_len(8'd255);
   endtask

   task automatic test_output_stall();
      int sent;
      wait_drained();
      calm     <= 1'b1;
      hold_seq <= hold_seq + 4'd1;
      for (int i = 0; i < 6; i++) send_frame(8'($urandom_range(20, 8)), sent);
      wait_drained();
      calm <= 1'b0;
   endtask

   task automatic test_random_frames();
      int sent;
      int phase_items;
      logic [7:0] lim;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: lim = 8'd255;
            1: lim = 8'd3;
            2: lim = 8'($urandom_range(254, 4));
            default: lim = 8'd254;
         endcase
         write_max_len(lim);
         // first phase runs with no idling on either side
         calm <= (p == 0);
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            send_frame(8'(pick_frame_len(lim)), sent);
            phase_items += sent;
         end
      end
      wait_drained();
      calm <= 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_frame_kinds();
      test_length_limit();
      test_limit_edge();
      test_output_stall();
      test_random_frames();
      wait_drained();
      $display("%0d requests in %0d frames, %0d framed bytes checked, %0d mismatches",
               requests_taken, frames_sent, bytes_checked, result_errors);
      $display("covered single, short, long, zero and oversize frames; limits 0 to 255");
      if (result_errors == 0 && framed_bytes_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[mbus_frame_builder.f]
rtl/core/mbfb_pkg.sv
rtl/core/mbfb_front.sv
rtl/core/mbfb_cmdq.sv
rtl/core/mbfb_back.sv
rtl/core/mbus_frame_builder.sv
tb/sv/tb_mbus_frame_builder.sv
